FILE: src/mlvf_pkg.sv
// Shared types, command codes and helpers of the multi-layer volume fader.
// Depends on nothing; used by mlvf_div, multi_layer_volume_fader and the testbench.
`default_nettype none
package mlvf_pkg;

	// Command codes carried by the cmd field.
	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_SET    = 3'd2;
	localparam logic [2:0] CMD_FADE   = 3'd3;
	localparam logic [2:0] CMD_TICK   = 3'd4;
	localparam logic [2:0] CMD_QUERY  = 3'd5;

	// Kinds of result beat.
	localparam logic REPLY_WRITE = 1'b0;
	localparam logic REPLY_QUERY = 1'b1;

	// Full level in unsigned Q15 and the width of a volume.
	localparam int unsigned VOL_W = 16;
	localparam logic [VOL_W-1:0] Q15_ONE = 16'h8000;

	// Handshake between the sequencer and the divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Clamp a signed Q15 request to the range 0 to full level.
	function automatic logic [VOL_W-1:0] clamp_q15(input logic signed [16:0] raw);
		logic [VOL_W-1:0] res;
		if (raw[16]) begin
			res = '0;
		end else if (raw[15:0] > Q15_ONE) begin
			res = Q15_ONE;
		end else begin
			res = raw[15:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

FILE: src/mlvf_div.sv
// Iterative restoring divider of the fader: one quotient bit per cycle.
// Depends on mlvf_pkg for the status struct and the volume width.
`default_nettype none
module mlvf_div #(
	parameter int unsigned DW = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [mlvf_pkg::VOL_W+DW-1:0]     dividend,
	input  wire logic [DW-1:0]                     divisor,
	output mlvf_pkg::div_stat_t                    stat,
	output logic [mlvf_pkg::VOL_W-1:0]             quotient
);

	localparam int unsigned QW = mlvf_pkg::VOL_W;
	localparam int unsigned CW = $clog2(QW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] num_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0] trial;
	logic        fits;

	// The caller guarantees the quotient fits in QW bits, so the high part
	// of the dividend is already below the divisor.
	assign trial = {rem_q, num_q[QW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[QW+DW-1:QW];
			num_q <= dividend[QW-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			num_q <= {num_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire

FILE: src/multi_layer_volume_fader.sv
// Multi-layer volume fader: slot table, command sequencer and output register.
// Depends on mlvf_pkg and on mlvf_div, the shared ramp divider.
//
// Usage: commands arrive as beats on the cmd channel (cmd_valid, cmd_stall,
// cmd, layer, volume_value, fade_ms). Results leave as beats on the res
// channel (res_valid, res_stall, out_layer, out_volume, reply_kind, last);
// last marks the final beat caused by one command.
// A command is taken only while the sequencer is idle. Remove and fade give
// no beat. Add, set and query give one beat, add only for a layer in range
// and set only for a present slot. A tick walks the slots one per cycle and
// stops at every present fading slot to read it, multiply, divide in the
// shared divider (one quotient bit per cycle; skipped on a ramp's final
// step), write back and emit its beat.
// The result register lets a new command in while a beat still waits; when
// res_stall holds the register full, the sequencer waits before its next beat.
// Reset clears the slot present and fading flags at once and empties the
// result register; the slot memory needs no clearing.
`default_nettype none
module multi_layer_volume_fader #(
	parameter int unsigned LAYERS        = 8,
	parameter int unsigned DURATION_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire logic [2:0]         cmd,
	input  wire logic [2:0]         layer,
	input  wire logic signed [16:0] volume_value,
	input  wire logic [15:0]        fade_ms,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [2:0]              out_layer,
	output logic [15:0]             out_volume,
	output logic                    reply_kind,
	output logic                    last
);

	localparam int unsigned DB = DURATION_BITS;
	localparam int unsigned VW = mlvf_pkg::VOL_W;
	localparam int unsigned IW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int unsigned SW = $clog2(LAYERS + 1);
	localparam int unsigned NW = VW + DB;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CMD   = 3'd1;
	localparam logic [2:0] S_TSCAN = 3'd2;
	localparam logic [2:0] S_TREAD = 3'd3;
	localparam logic [2:0] S_TMUL  = 3'd4;
	localparam logic [2:0] S_TDIV  = 3'd5;
	localparam logic [2:0] S_TWB   = 3'd6;
	localparam logic [2:0] S_EMIT  = 3'd7;

	logic [2:0]        state_q;
	logic [2:0]        cmd_q;
	logic [2:0]        layer_q;
	logic [VW-1:0]     cvol_q;
	logic [DB-1:0]     clen_q;
	logic [SW-1:0]     slot_q;
	logic [DB-1:0]     el_q;
	logic              neg_q;
	logic              fin_q;
	logic [VW-1:0]     vol_q;
	logic              ret_tick_q;
	logic [LAYERS-1:0] present_q;
	logic [LAYERS-1:0] active_q;

	logic [2:0]        res_layer_q;
	logic [VW-1:0]     res_vol_q;
	logic              res_kind_q;
	logic              res_last_q;

	logic              out_valid_q;
	logic [2:0]        out_layer_q;
	logic [VW-1:0]     out_vol_q;
	logic              out_kind_q;
	logic              out_last_q;

	// Slot memory, one word per slot split into fields.
	logic [VW-1:0] mem_now   [LAYERS];
	logic [VW-1:0] mem_start [LAYERS];
	logic [VW-1:0] mem_goal  [LAYERS];
	logic [DB-1:0] mem_len   [LAYERS];
	logic [DB-1:0] mem_el    [LAYERS];
	logic [VW-1:0] rd_now_q;
	logic [VW-1:0] rd_start_q;
	logic [VW-1:0] rd_goal_q;
	logic [DB-1:0] rd_len_q;
	logic [DB-1:0] rd_el_q;

	logic          mem_we;
	logic [IW-1:0] wr_addr;
	logic [IW-1:0] rd_addr;
	logic [VW-1:0] wr_now;
	logic [VW-1:0] wr_start;
	logic [VW-1:0] wr_goal;
	logic [DB-1:0] wr_len;
	logic [DB-1:0] wr_el;

	logic          accept;
	logic [IW-1:0] lidx;
	logic [IW-1:0] sidx;
	logic          in_range;
	logic          ok;
	logic          out_free;
	logic          later_pa;
	logic [DB-1:0] len_sat;
	logic signed [16:0] diff;
	logic [VW-1:0] mag;
	logic [NW-1:0] prod;
	logic          div_start;
	mlvf_pkg::div_stat_t div_st;
	logic [VW-1:0] quo;
	logic signed [16:0] ramp_sum;

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign lidx      = IW'(layer_q);
	assign sidx      = slot_q[IW-1:0];
	assign in_range  = 32'(layer_q) < LAYERS;
	assign ok        = in_range && present_q[lidx];
	assign out_free  = !out_valid_q || !res_stall;
	assign rd_addr   = (state_q == S_IDLE) ? IW'(layer) : sidx;

	always_comb begin
		if (DB < 16 && (fade_ms >> DB) != 16'd0) begin
			len_sat = '1;
		end else begin
			len_sat = DB'(fade_ms);
		end
	end

	// A later fading slot means the present beat is not the last of a tick.
	always_comb begin
		later_pa = 1'b0;
		for (int i = 0; i < LAYERS; i++) begin
			if (present_q[i] && active_q[i] && (i > 32'(slot_q))) begin
				later_pa = 1'b1;
			end
		end
	end

	assign diff      = $signed({1'b0, rd_goal_q}) - $signed({1'b0, rd_start_q});
	assign mag       = diff[16] ? VW'(-diff) : diff[VW-1:0];
	assign prod      = NW'(mag) * NW'(el_q);
	assign div_start = (state_q == S_TMUL) && (el_q < rd_len_q);
	assign ramp_sum  = neg_q ? ($signed({1'b0, rd_start_q}) - $signed({1'b0, quo}))
	                         : ($signed({1'b0, rd_start_q}) + $signed({1'b0, quo}));

	mlvf_div #(
		.DW(DB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (rd_len_q),
		.stat     (div_st),
		.quotient (quo)
	);

	// Memory write port.
	always_comb begin
		mem_we   = 1'b0;
		wr_addr  = lidx;
		wr_now   = rd_now_q;
		wr_start = rd_start_q;
		wr_goal  = rd_goal_q;
		wr_len   = rd_len_q;
		wr_el    = rd_el_q;
		unique case (state_q)
			S_CMD: begin
				unique case (cmd_q)
					mlvf_pkg::CMD_ADD: begin
						mem_we = in_range;
						wr_now = '0;
					end
					mlvf_pkg::CMD_SET: begin
						mem_we  = ok;
						wr_now  = cvol_q;
						wr_goal = cvol_q;
					end
					mlvf_pkg::CMD_FADE: begin
						mem_we   = ok;
						wr_start = rd_now_q;
						wr_goal  = cvol_q;
						wr_len   = clen_q;
						wr_el    = '0;
					end
					default: begin
						mem_we = 1'b0;
					end
				endcase
			end
			S_TWB: begin
				mem_we  = 1'b1;
				wr_addr = sidx;
				wr_now  = vol_q;
				wr_el   = el_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_now[wr_addr]   <= wr_now;
			mem_start[wr_addr] <= wr_start;
			mem_goal[wr_addr]  <= wr_goal;
			mem_len[wr_addr]   <= wr_len;
			mem_el[wr_addr]    <= wr_el;
		end
		rd_now_q   <= mem_now[rd_addr];
		rd_start_q <= mem_start[rd_addr];
		rd_goal_q  <= mem_goal[rd_addr];
		rd_len_q   <= mem_len[rd_addr];
		rd_el_q    <= mem_el[rd_addr];
	end

	// Sequencer and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			present_q  <= '0;
			active_q   <= '0;
			slot_q     <= '0;
			ret_tick_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_CMD;
					end
				end
				S_CMD: begin
					ret_tick_q <= 1'b0;
					state_q    <= S_IDLE;
					unique case (cmd_q)
						mlvf_pkg::CMD_ADD: begin
							if (in_range) begin
								present_q[lidx] <= 1'b1;
								active_q[lidx]  <= 1'b0;
								state_q         <= S_EMIT;
							end
						end
						mlvf_pkg::CMD_REMOVE: begin
							if (ok) begin
								present_q[lidx] <= 1'b0;
								active_q[lidx]  <= 1'b0;
							end
						end
						mlvf_pkg::CMD_SET: begin
							if (ok) begin
								active_q[lidx] <= 1'b0;
								state_q        <= S_EMIT;
							end
						end
						mlvf_pkg::CMD_FADE: begin
							if (ok) begin
								active_q[lidx] <= 1'b1;
							end
						end
						mlvf_pkg::CMD_TICK: begin
							slot_q  <= '0;
							state_q <= S_TSCAN;
						end
						mlvf_pkg::CMD_QUERY: begin
							state_q <= S_EMIT;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_TSCAN: begin
					if (32'(slot_q) >= LAYERS) begin
						state_q <= S_IDLE;
					end else if (present_q[sidx] && active_q[sidx]) begin
						state_q <= S_TREAD;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_TREAD: begin
					state_q <= S_TMUL;
				end
				S_TMUL: begin
					state_q <= div_start ? S_TDIV : S_TWB;
				end
				S_TDIV: begin
					if (div_st.done) begin
						state_q <= S_TWB;
					end
				end
				S_TWB: begin
					if (fin_q) begin
						active_q[sidx] <= 1'b0;
					end
					ret_tick_q <= 1'b1;
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (ret_tick_q) begin
							slot_q  <= slot_q + 1'b1;
							state_q <= S_TSCAN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command latch, ramp datapath and result staging registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			layer_q <= layer;
			cvol_q  <= mlvf_pkg::clamp_q15(volume_value);
			clen_q  <= len_sat;
		end
		if (state_q == S_TREAD) begin
			el_q <= (rd_el_q == {DB{1'b1}}) ? rd_el_q : rd_el_q + 1'b1;
		end
		if (state_q == S_TMUL) begin
			neg_q <= diff[16];
			fin_q <= !div_start;
			vol_q <= rd_goal_q;
		end
		if (state_q == S_TDIV && div_st.done) begin
			vol_q <= ramp_sum[VW-1:0];
		end
		if (state_q == S_CMD) begin
			res_layer_q <= layer_q;
			res_last_q  <= 1'b1;
			unique case (cmd_q)
				mlvf_pkg::CMD_SET: begin
					res_vol_q  <= cvol_q;
					res_kind_q <= mlvf_pkg::REPLY_WRITE;
				end
				mlvf_pkg::CMD_QUERY: begin
					res_vol_q  <= ok ? rd_now_q : '0;
					res_kind_q <= mlvf_pkg::REPLY_QUERY;
				end
				default: begin
					res_vol_q  <= '0;
					res_kind_q <= mlvf_pkg::REPLY_WRITE;
				end
			endcase
		end
		if (state_q == S_TWB) begin
			res_layer_q <= 3'(slot_q);
			res_vol_q   <= vol_q;
			res_kind_q  <= mlvf_pkg::REPLY_WRITE;
			res_last_q  <= !later_pa;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_layer_q <= res_layer_q;
			out_vol_q   <= res_vol_q;
			out_kind_q  <= res_kind_q;
			out_last_q  <= res_last_q;
		end
	end

	assign res_valid  = out_valid_q;
	assign out_layer  = out_layer_q;
	assign out_volume = out_vol_q;
	assign reply_kind = out_kind_q;
	assign last       = out_last_q;

	// The divider reports a result only while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == S_TDIV))
		else $error("divider finished outside the divide step");

	// While waiting on the divider, it must be running or finishing.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TDIV) |-> (div_st.busy || div_st.done))
		else $error("sequencer waits on an idle divider");

	// A ramp is written back only for a slot that is present and fading.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TWB) |-> (present_q[sidx] && active_q[sidx]))
		else $error("ramp write back to a slot that is not fading");

	// No result beat carries a level above full scale.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_vol_q <= mlvf_pkg::Q15_ONE))
		else $error("result volume above full level");

endmodule
`default_nettype wire

FILE: tb/sv/multi_layer_volume_fader_test.sv
// Self-checking testbench for multi_layer_volume_fader: a scoreboard class mirrors the slot
// table and ramps; tasks send commands with random gaps and results are stalled at random.
// Depends on mlvf_pkg and the multi_layer_volume_fader RTL.
`timescale 1ns / 1ps
module multi_layer_volume_fader_test;

	// Command codes the block must ignore.
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;

	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 500;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 250;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	class fader_scoreboard;
		typedef struct packed {
			logic [2:0]  lyr;
			logic [15:0] vol;
			logic        kind;
			logic        fin;
		} beat_t;

		beat_t    pending_q[$];
		bit       present[8];
		bit       fading[8];
		bit [15:0] level[8];
		bit [15:0] ramp_from[8];
		bit [15:0] ramp_to[8];
		bit [15:0] ramp_len[8];
		bit [15:0] ramp_pos[8];
		int errors;
		int acted;
		int writes;
		int replies;
		int fades;
		int busiest_tick;

		function bit [15:0] limit_level(logic signed [16:0] raw);
			bit [15:0] res;
			if (raw < 0) begin
				res = 16'd0;
			end else if (raw > 17'sd32768) begin
				res = mlvf_pkg::Q15_ONE;
			end else begin
				res = raw[15:0];
			end
			return res;
		endfunction

		function void push_beat(logic [2:0] l, logic [15:0] v, logic k);
			beat_t b;
			b.lyr = l;
			b.vol = v;
			b.kind = k;
			b.fin = 1'b0;
			pending_q.push_back(b);
		endfunction

		// Advances the mirror by one accepted command beat and queues what it should produce.
		function void note_command(logic [2:0] c, logic [2:0] l, logic signed [16:0] v,
				logic [15:0] ms);
			int first;
			int i;
			longint diff;
			longint step;
			first = pending_q.size();
			case (c)
				mlvf_pkg::CMD_ADD: begin
					present[l] = 1;
					level[l] = 0;
					fading[l] = 0;
					push_beat(l, 16'd0, mlvf_pkg::REPLY_WRITE);
					acted++;
				end
				mlvf_pkg::CMD_REMOVE: begin
					if (present[l]) begin
						present[l] = 0;
						fading[l] = 0;
						acted++;
					end
				end
				mlvf_pkg::CMD_SET: begin
					if (present[l]) begin
						level[l] = limit_level(v);
						ramp_to[l] = level[l];
						fading[l] = 0;
						push_beat(l, level[l], mlvf_pkg::REPLY_WRITE);
						acted++;
					end
				end
				mlvf_pkg::CMD_FADE: begin
					if (present[l]) begin
						ramp_from[l] = level[l];
						ramp_to[l] = limit_level(v);
						ramp_len[l] = ms;
						ramp_pos[l] = 0;
						fading[l] = 1;
						fades++;
						acted++;
					end
				end
				mlvf_pkg::CMD_TICK: begin
					for (i = 0; i < 8; i++) begin
						if (present[i] && fading[i]) begin
							if (ramp_pos[i] != LEN_MAX)
								ramp_pos[i]++;
							if (ramp_pos[i] >= ramp_len[i]) begin
								level[i] = ramp_to[i];
								fading[i] = 0;
							end else begin
								// Signed division truncates toward zero, as the ramp requires.
								diff = longint'(ramp_to[i]) - longint'(ramp_from[i]);
								step = (diff * longint'(ramp_pos[i])) / longint'(ramp_len[i]);
								level[i] = 16'(longint'(ramp_from[i]) + step);
							end
							push_beat(3'(i), level[i], mlvf_pkg::REPLY_WRITE);
						end
					end
					if (pending_q.size() - first > busiest_tick)
						busiest_tick = pending_q.size() - first;
					acted++;
				end
				mlvf_pkg::CMD_QUERY: begin
					push_beat(l, present[l] ? level[l] : 16'd0, mlvf_pkg::REPLY_QUERY);
					acted++;
				end
				default: begin
				end
			endcase
			if (pending_q.size() > first)
				pending_q[pending_q.size() - 1].fin = 1'b1;
		endfunction

		function void check_result(logic [2:0] l, logic [15:0] v, logic k, logic f);
			beat_t exp_beat;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result beat with nothing expected: layer %0d volume %0d kind %0d last %0d",
						l, v, k, f);
			end else begin
				exp_beat = pending_q.pop_front();
				if (k == mlvf_pkg::REPLY_QUERY)
					replies++;
				else
					writes++;
				if (l !== exp_beat.lyr || v !== exp_beat.vol || k !== exp_beat.kind ||
						f !== exp_beat.fin) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch: expected layer %0d volume %0d kind %0d last %0d,",
							exp_beat.lyr, exp_beat.vol, exp_beat.kind, exp_beat.fin);
						$display("          got layer %0d volume %0d kind %0d last %0d",
							l, v, k, f);
					end
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_stall;
	logic [2:0]         cmd;
	logic [2:0]         layer;
	logic signed [16:0] volume_value;
	logic [15:0]        fade_ms;
	logic               res_valid;
	logic               res_stall;
	logic [2:0]         out_layer;
	logic [15:0]        out_volume;
	logic               reply_kind;
	logic               last;

	fader_scoreboard sb;
	bit calm;
	bit hold_req;

	multi_layer_volume_fader dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.layer(layer),
		.volume_value(volume_value),
		.fade_ms(fade_ms),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_layer(out_layer),
		.out_volume(out_volume),
		.reply_kind(reply_kind),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", CYCLE_LIMIT);
		$display("multi_layer_volume_fader_test: errors");
		$finish;
	end

	// Results are checked before the command of the same edge is noted; a command never
	// produces a beat at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				sb.check_result(out_layer, out_volume, reply_kind, last);
			if (cmd_valid && !cmd_stall)
				sb.note_command(cmd, layer, volume_value, fade_ms);
		end
	end

	// Result side: a random stall before each beat, and one long hold-off on request.
	initial begin
		int gap;
		res_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			gap = calm ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!(res_valid && !res_stall) && !hold_req)
				@(posedge clk);
		end
	end

	task automatic send(input logic [2:0] c, input logic [2:0] l, input logic signed [16:0] v,
			input logic [15:0] ms);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		layer <= l;
		volume_value <= v;
		fade_ms <= ms;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	// Lets every expected beat arrive before the sender goes on.
	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [16:0] random_level();
		logic signed [16:0] v;
		if ($urandom_range(0, 99) < 70)
			v = 17'($urandom_range(0, 32768));
		else
			v = 17'($urandom);
		return v;
	endfunction

	task automatic send_random();
		int pick;
		logic [2:0] c;
		logic [15:0] ms;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 80)
			ms = 16'($urandom_range(0, 12));
		else if ($urandom_range(0, 3) != 0)
			ms = 16'($urandom_range(13, 300));
		else
			ms = 16'($urandom);
		if (pick < 8)
			c = mlvf_pkg::CMD_ADD;
		else if (pick < 14)
			c = mlvf_pkg::CMD_REMOVE;
		else if (pick < 28)
			c = mlvf_pkg::CMD_SET;
		else if (pick < 46)
			c = mlvf_pkg::CMD_FADE;
		else if (pick < 78)
			c = mlvf_pkg::CMD_TICK;
		else if (pick < 95)
			c = mlvf_pkg::CMD_QUERY;
		else
			c = pick[0] ? CMD_SPARE_A : CMD_SPARE_B;
		send(c, 3'($urandom_range(0, 7)), random_level(), ms);
	endtask

	// A well-formed fade: make sure the slot exists, start a short ramp and tick it to its end,
	// peeking at the level along the way.
	task automatic ramp_walk();
		logic [2:0] l;
		int n;
		int i;
		l = 3'($urandom_range(0, 7));
		n = $urandom_range(0, 9);
		if (!sb.present[l])
			send(mlvf_pkg::CMD_ADD, l, 17'sd0, 16'd0);
		if ($urandom_range(0, 1) == 1)
			send(mlvf_pkg::CMD_SET, l, random_level(), 16'd0);
		send(mlvf_pkg::CMD_FADE, l, random_level(), 16'(n));
		for (i = 0; i <= n; i++) begin
			send(mlvf_pkg::CMD_TICK, 3'($urandom_range(0, 7)), random_level(), 16'($urandom));
			if ($urandom_range(0, 2) == 0)
				send(mlvf_pkg::CMD_QUERY, l, 17'sd0, 16'd0);
		end
	endtask

	initial begin
		int round;
		int goal;
		sb = new();
		calm = 1'b0;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= mlvf_pkg::CMD_TICK;
		layer <= 3'd0;
		volume_value <= 17'sd0;
		fade_ms <= 16'd0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Commands to missing slots and unused codes, then clamping and ramp corners.
		send(mlvf_pkg::CMD_QUERY, 3'd3, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_REMOVE, 3'd3, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_SET, 3'd3, 17'sd1000, 16'd0);
		send(mlvf_pkg::CMD_FADE, 3'd3, 17'sd1000, 16'd5);
		send(CMD_SPARE_A, 3'd5, 17'sd200, 16'd1);
		send(CMD_SPARE_B, 3'd2, 17'sd300, 16'd2);
		send(mlvf_pkg::CMD_TICK, 3'd0, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_ADD, 3'd0, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_ADD, 3'd7, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_SET, 3'd0, -17'sd65536, 16'd0);
		send(mlvf_pkg::CMD_SET, 3'd7, 17'sd65535, 16'd0);
		send(mlvf_pkg::CMD_SET, 3'd0, 17'sd32767, 16'd0);
		send(mlvf_pkg::CMD_FADE, 3'd7, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_TICK, 3'd0, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_FADE, 3'd0, 17'sd40000, 16'd3);
		send(mlvf_pkg::CMD_TICK, 3'd0, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_TICK, 3'd0, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_TICK, 3'd0, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_FADE, 3'd0, 17'sd100, 16'd7);
		send(mlvf_pkg::CMD_TICK, 3'd0, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_FADE, 3'd7, 17'sd12345, 16'hFFFF);
		send(mlvf_pkg::CMD_TICK, 3'd0, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_QUERY, 3'd7, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_ADD, 3'd7, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_REMOVE, 3'd0, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_QUERY, 3'd0, 17'sd0, 16'd0);
		send(mlvf_pkg::CMD_TICK, 3'd0, 17'sd0, 16'd0);

		goal = sb.acted + RANDOM_ITEMS;
		round = 0;
		while (sb.acted < goal) begin
			calm = ((round / 50) % 5) == 4;
			if (round == 120)
				hold_req = 1'b1;
			if (round == 200)
				drain();
			if ($urandom_range(0, 9) == 0)
				ramp_walk();
			else
				send_random();
			round++;
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending_q.size() != 0) begin
			sb.errors += sb.pending_q.size();
			$display("%0d expected beats never arrived", sb.pending_q.size());
		end
		$display("Covered %0d effective commands and %0d fades, checked %0d writes and %0d replies.",
			sb.acted, sb.fades, sb.writes, sb.replies);
		$display("The busiest tick produced %0d beats; one long result hold-off filled the block.",
			sb.busiest_tick);
		if (sb.errors == 0)
			$display("multi_layer_volume_fader_test: clean");
		else
			$display("multi_layer_volume_fader_test: errors");
		$finish;
	end
endmodule
